>>> rtl/core/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/utt_pkg.sv
// Package: types and constants of the UTF-8 to UTF-16 transcoder.
package utt_pkg;

    // byte classification masks and tags
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;

    // surrogate pair construction
    localparam logic [20:0] PLANE1_BASE = 21'h10000;
    localparam logic [15:0] SURR_HIGH   = 16'hD800;
    localparam logic [15:0] SURR_LOW    = 16'hDC00;

    // number of code units one input byte can cause
    localparam int MAX_UNITS = 4;

    // held sequence state
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      held;
        logic [1:0]      needed;
    } utt_state_t;

    // code units caused by one byte, handed to the output buffer
    typedef struct packed {
        logic [MAX_UNITS-1:0][15:0] units;
        logic [2:0]                 count;
        logic                       str_end;
    } utt_bundle_t;

endpackage

>>> rtl/core/utt_decode.sv
// Decoder: turns one byte and the held sequence into code units and next state.
module utt_decode (
    input  logic [7:0]          in_byte,
    input  logic                str_end,
    input  utt_pkg::utt_state_t state_cur,
    output utt_pkg::utt_state_t state_next,
    output utt_pkg::utt_bundle_t bundle
);

    logic        is_cont;
    logic [1:0]  need;
    logic        fresh_hold;
    logic [20:0] cp;
    logic [20:0] cp_off;
    logic [15:0] unit_byte;

    // classify the byte
    always_comb
    begin
        is_cont = ((in_byte & utt_pkg::CONT_MASK) == utt_pkg::CONT_TAG);
        priority if ((in_byte & utt_pkg::LEAD2_MASK) == utt_pkg::LEAD2_TAG)
            need = 2'd1;
        else if ((in_byte & utt_pkg::LEAD3_MASK) == utt_pkg::LEAD3_TAG)
            need = 2'd2;
        else if ((in_byte & utt_pkg::LEAD4_MASK) == utt_pkg::LEAD4_TAG)
            need = 2'd3;
        else
            need = 2'd0;
        fresh_hold = (need != 2'd0) && !str_end;
        unit_byte  = {8'h00, in_byte};
    end

    // assemble the code point of a completed sequence
    always_comb
    begin
        unique case (state_cur.needed)
            2'd1:
                cp = {10'd0, state_cur.bytes[0][4:0], in_byte[5:0]};
            2'd2:
                cp = {5'd0, state_cur.bytes[0][3:0], state_cur.bytes[1][5:0],
                      in_byte[5:0]};
            default:
                cp = {state_cur.bytes[0][2:0], state_cur.bytes[1][5:0],
                      state_cur.bytes[2][5:0], in_byte[5:0]};
        endcase
        cp_off = cp - utt_pkg::PLANE1_BASE;
    end

    // next state and emitted units
    always_comb
    begin
        state_next     = state_cur;
        bundle.units   = '0;
        bundle.count   = 3'd0;
        bundle.str_end = str_end;

        if (state_cur.held == 2'd0)
        begin
            // nothing held: handle the byte fresh
            if (fresh_hold)
            begin
                state_next.bytes[0] = in_byte;
                state_next.held     = 2'd1;
                state_next.needed   = need;
            end
            else
            begin
                bundle.units[0] = unit_byte;
                bundle.count    = 3'd1;
            end
        end
        else if (is_cont && (state_cur.held >= state_cur.needed))
        begin
            // sequence complete
            state_next.held   = 2'd0;
            state_next.needed = 2'd0;
            if (|cp[20:16])
            begin
                bundle.units[0] = utt_pkg::SURR_HIGH + {5'd0, cp_off[20:10]};
                bundle.units[1] = utt_pkg::SURR_LOW + {6'd0, cp_off[9:0]};
                bundle.count    = 3'd2;
            end
            else
            begin
                bundle.units[0] = cp[15:0];
                bundle.count    = 3'd1;
            end
        end
        else if (is_cont)
        begin
            // append the continuation byte
            unique case (state_cur.held)
                2'd1:    state_next.bytes[1] = in_byte;
                2'd2:    state_next.bytes[2] = in_byte;
                default: state_next.bytes[0] = state_cur.bytes[0];
            endcase
            state_next.held = state_cur.held + 2'd1;
            if (str_end)
            begin
                // string ends mid-sequence: flush every held byte
                for (int i = 0; i < 3; i++)
                begin
                    if (2'(i) < state_next.held)
                        bundle.units[i] = {8'h00, state_next.bytes[i]};
                end
                bundle.count      = {1'b0, state_next.held};
                state_next.held   = 2'd0;
                state_next.needed = 2'd0;
            end
        end
        else
        begin
            // broken sequence: flush held bytes, then take the byte fresh
            for (int i = 0; i < 3; i++)
            begin
                if (2'(i) < state_cur.held)
                    bundle.units[i] = {8'h00, state_cur.bytes[i]};
            end
            if (fresh_hold)
            begin
                state_next.bytes[0] = in_byte;
                state_next.held     = 2'd1;
                state_next.needed   = need;
                bundle.count        = {1'b0, state_cur.held};
            end
            else
            begin
                bundle.units[state_cur.held] = unit_byte;
                bundle.count                 = {1'b0, state_cur.held} + 3'd1;
                state_next.held              = 2'd0;
                state_next.needed            = 2'd0;
            end
        end
    end

endmodule

>>> rtl/core/utt_outbuf.sv
// Output buffer: holds the code units of one byte and drains them one per transfer.
module utt_outbuf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  utt_pkg::utt_bundle_t  bundle,
    output logic                  free,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           code_unit,
    output logic                  run_last,
    output logic                  string_last
);

    logic [utt_pkg::MAX_UNITS-1:0][15:0] units_reg, units_next;
    logic                                end_reg, end_next;
    logic                                valid_reg, valid_next;
    logic [1:0]                          idx_reg, idx_next;
    logic [1:0]                          last_idx_reg, last_idx_next;
    logic                                last;
    logic                                xfer;

    // drain control
    always_comb
    begin
        last = (idx_reg == last_idx_reg);
        xfer = valid_reg && !out_stall;
        free = !valid_reg || (xfer && last);

        units_next    = units_reg;
        end_next      = end_reg;
        valid_next    = valid_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;

        if (load)
        begin
            units_next    = bundle.units;
            end_next      = bundle.str_end;
            valid_next    = 1'b1;
            idx_next      = 2'd0;
            last_idx_next = bundle.count[1:0] - 2'd1;
        end
        else if (xfer && last)
            valid_next = 1'b0;
        else if (xfer)
            idx_next = idx_reg + 2'd1;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= 1'b0;
            idx_reg      <= 2'd0;
            last_idx_reg <= 2'd0;
        end
        else
        begin
            valid_reg    <= valid_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        units_reg <= units_next;
        end_reg   <= end_next;
    end

    assign out_valid   = valid_reg;
    assign code_unit   = units_reg[idx_reg];
    assign run_last    = last;
    assign string_last = last && end_reg;

endmodule

>>> rtl/core/utf8_to_utf16_transcoder_top.sv
// UTF-8 to UTF-16 transcoder: top level with input register and held-sequence state.
// An input byte is registered in the input stage, decoded, and its code units are
// loaded into the output buffer registers that drive the port.
// Throughput: one byte per cycle unless stalled; the buffer moves one code unit per
// cycle without out_stall; while extra units drain, input bytes with units stall.
// Reset: clears the input stage, held and needed counts and the output buffer;
// held bytes are not reset.
module utf8_to_utf16_transcoder_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        string_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        run_last,
    output logic        string_last
);

    logic                 s1_valid_reg, s1_valid_next;
    logic [7:0]           s1_byte_reg, s1_byte_next;
    logic                 s1_end_reg, s1_end_next;
    logic [2:0][7:0]      held_bytes_reg, held_bytes_next;
    logic [1:0]           held_count_reg, held_count_next;
    logic [1:0]           needed_count_reg, needed_count_next;

    utt_pkg::utt_state_t  state_cur;
    utt_pkg::utt_state_t  state_next;
    utt_pkg::utt_bundle_t bundle;
    logic                 free;
    logic                 has_units;
    logic                 s1_adv;
    logic                 in_xfer;

    // current held sequence
    always_comb
    begin
        state_cur.bytes  = held_bytes_reg;
        state_cur.held   = held_count_reg;
        state_cur.needed = needed_count_reg;
    end

    utt_decode u_decode (
        .in_byte    (s1_byte_reg),
        .str_end    (s1_end_reg),
        .state_cur  (state_cur),
        .state_next (state_next),
        .bundle     (bundle)
    );

    // advance: bytes that cause no unit never wait for the buffer
    always_comb
    begin
        has_units = (bundle.count != 3'd0);
        s1_adv    = s1_valid_reg && (!has_units || free);
        in_stall  = s1_valid_reg && !s1_adv;
        in_xfer   = in_valid && !in_stall;
    end

    // next values of the input stage and the held state
    always_comb
    begin
        s1_valid_next     = s1_valid_reg;
        s1_byte_next      = s1_byte_reg;
        s1_end_next       = s1_end_reg;
        held_bytes_next   = held_bytes_reg;
        held_count_next   = held_count_reg;
        needed_count_next = needed_count_reg;

        if (in_xfer)
        begin
            s1_valid_next = 1'b1;
            s1_byte_next  = in_byte;
            s1_end_next   = string_end;
        end
        else if (s1_adv)
            s1_valid_next = 1'b0;

        if (s1_adv)
        begin
            held_bytes_next   = state_next.bytes;
            held_count_next   = state_next.held;
            needed_count_next = state_next.needed;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            held_count_reg   <= 2'd0;
            needed_count_reg <= 2'd0;
        end
        else
        begin
            s1_valid_reg     <= s1_valid_next;
            held_count_reg   <= held_count_next;
            needed_count_reg <= needed_count_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_byte_reg    <= s1_byte_next;
        s1_end_reg     <= s1_end_next;
        held_bytes_reg <= held_bytes_next;
    end

    utt_outbuf u_outbuf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (s1_adv && has_units),
        .bundle      (bundle),
        .free        (free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_unit   (code_unit),
        .run_last    (run_last),
        .string_last (string_last)
    );

endmodule

>>> rtl/core/utt_checker.sv
// Checker on the top-level ports of the transcoder, with its bind.
`include "assert_macros.svh"

module utt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] code_unit,
    input logic        run_last,
    input logic        string_last
);

    logic [17:0] out_word;

    // whole result as seen on the port
    assign out_word = {code_unit, run_last, string_last};

    // a stalled result holds
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word))

    // the end of a string also closes the run of its byte
    `ASSERT_IMPLIES(a_str_last_run, clk, rst_n, out_valid && string_last, run_last)

    // a run of several units continues without a gap
    `ASSERT_NEXT(a_run_cont, clk, rst_n, out_valid && !out_stall && !run_last, out_valid)

    // with the output buffer empty, input is never stalled
    `ASSERT_IMPLIES(a_no_stall_idle, clk, rst_n, !out_valid, !in_stall)

endmodule

bind utf8_to_utf16_transcoder_top utt_checker u_checker (.*);

>>> sim/utf16_unit_checker.sv
// Transfer monitor, code-unit predictor and scoreboard for the UTF-8 to UTF-16 transcoder.
module utf16_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        string_end,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] code_unit,
    input  logic        run_last,
    input  logic        string_last,
    output int          fail_count,
    output int          pending,
    output int          bytes_taken,
    output int          units_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] value;
        logic        run_end;
        logic        str_end;
    } unit_exp_t;

    // predicted code units still to arrive, oldest first
    unit_exp_t   expected_units[$];
    // units caused by the byte being predicted
    logic [15:0] step_units[$];
    unit_exp_t   want;

    // held sequence as the predictor sees it
    logic [7:0]  seq_bytes [3];
    logic [1:0]  seq_held;
    logic [1:0]  seq_need;

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        fail_count++;
        if (fail_count <= 30)
            $display("MISMATCH @%0t: %s: got %h, expected %h", $time, what, got, exp_val);
    endtask

    // each held byte goes out as a unit of its own
    function automatic void flush_held_bytes();
        for (int i = 0; i < int'(seq_held); i++)
            step_units.push_back({8'h00, seq_bytes[i]});
        seq_held = 2'd0;
        seq_need = 2'd0;
    endfunction

    function automatic void predict_units(input logic [7:0] b, input logic last);
        logic        absorbed;
        logic        is_final;
        logic [1:0]  lead_need;
        logic [20:0] point;
        logic [20:0] offset;
        step_units.delete();
        absorbed = 1'b0;
        if (seq_held != 2'd0) begin
            if ((b & utt_pkg::CONT_MASK) == utt_pkg::CONT_TAG) begin
                absorbed = 1'b1;
                if (seq_held >= seq_need) begin
                    // sequence complete: assemble the code point
                    unique case (seq_need)
                        2'd1:    point = 21'(seq_bytes[0] & 8'h1F);
                        2'd2:    point = 21'(seq_bytes[0] & 8'h0F);
                        default: point = 21'(seq_bytes[0] & 8'h07);
                    endcase
                    for (int i = 1; i < int'(seq_held); i++)
                        point = (point << 6) | 21'(seq_bytes[i][5:0]);
                    point = (point << 6) | 21'(b[5:0]);
                    if (point <= 21'h00FFFF) begin
                        step_units.push_back(point[15:0]);
                    end
                    else begin
                        // surrogate pair, high half kept to 16 bits
                        offset = point - utt_pkg::PLANE1_BASE;
                        step_units.push_back(utt_pkg::SURR_HIGH + 16'(offset[20:10]));
                        step_units.push_back(utt_pkg::SURR_LOW + 16'(offset[9:0]));
                    end
                    seq_held = 2'd0;
                    seq_need = 2'd0;
                end
                else begin
                    if (seq_held < 2'd3) begin
                        seq_bytes[seq_held] = b;
                        seq_held = seq_held + 2'd1;
                    end
                    if (last)
                        flush_held_bytes();
                end
            end
            else begin
                flush_held_bytes();
            end
        end

        // fresh byte: open a sequence or pass it straight through
        if (!absorbed) begin
            if ((b & utt_pkg::LEAD2_MASK) == utt_pkg::LEAD2_TAG)
                lead_need = 2'd1;
            else if ((b & utt_pkg::LEAD3_MASK) == utt_pkg::LEAD3_TAG)
                lead_need = 2'd2;
            else if ((b & utt_pkg::LEAD4_MASK) == utt_pkg::LEAD4_TAG)
                lead_need = 2'd3;
            else
                lead_need = 2'd0;
            if (lead_need != 2'd0 && !last) begin
                seq_bytes[0] = b;
                seq_held = 2'd1;
                seq_need = lead_need;
            end
            else begin
                step_units.push_back({8'h00, b});
            end
        end

        foreach (step_units[i]) begin
            is_final = (i == step_units.size() - 1);
            expected_units.push_back('{value: step_units[i], run_end: is_final,
                                       str_end: is_final && last});
        end
    endfunction

    // compare output transfers, then predict from input transfers
    always @(posedge clk) begin
        if (!rst_n) begin
            seq_held = 2'd0;
            seq_need = 2'd0;
            expected_units.delete();
        end
        else begin
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                units_checked++;
                if (expected_units.size() == 0) begin
                    report_mismatch("code unit with nothing pending", code_unit, 16'h0000);
                end
                else begin
                    want = expected_units.pop_front();
                    if (code_unit !== want.value)
                        report_mismatch("code_unit", code_unit, want.value);
                    if (run_last !== want.run_end)
                        report_mismatch("run_last", 16'(run_last), 16'(want.run_end));
                    if (string_last !== want.str_end)
                        report_mismatch("string_last", 16'(string_last), 16'(want.str_end));
                end
            end
            if (in_valid === 1'b1 && in_stall === 1'b0) begin
                bytes_taken++;
                predict_units(in_byte, string_end);
            end
        end
        pending = expected_units.size();
    end

endmodule

>>> sim/tb.sv
// Testbench top: stimulus, receiver stalls and verdict for the UTF-8 to UTF-16 transcoder.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_CYCLES = 60;

    // directed bytes, {string_end, byte}
    localparam logic [8:0] DIRECTED [25] = '{
        9'h001, 9'h0FF, 9'h080,                 // low byte, F8-FF byte, stray continuation
        9'h0C3, 9'h0A9,                         // two-byte form
        9'h0E2, 9'h082, 9'h0AC,                 // three-byte form
        9'h0F0, 9'h09F, 9'h098, 9'h080,         // surrogate pair
        9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,         // beyond 10FFFF, truncated pair
        9'h0C0, 9'h080,                         // overlong form
        9'h0F0, 9'h09F, 9'h098, 9'h041,         // broken by ASCII: four units
        9'h1C3,                                 // lead byte at string end
        9'h0E2, 9'h1BF                          // string ends mid-sequence
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_byte;
    logic        string_end;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] code_unit;
    logic        run_last;
    logic        string_last;

    int          fail_count;
    int          pending;
    int          bytes_taken;
    int          units_checked;
    int          items_sent;
    int          strings_sent;
    bit          idle_on;
    bit          hold_req;
    logic [7:0]  text_q[$];

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    utf8_to_utf16_transcoder_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .string_end  (string_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_unit   (code_unit),
        .run_last    (run_last),
        .string_last (string_last)
    );

    utf16_unit_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .string_end    (string_end),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .code_unit     (code_unit),
        .run_last      (run_last),
        .string_last   (string_last),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_taken   (bytes_taken),
        .units_checked (units_checked)
    );

    // mostly none or short, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 24);
    endfunction

    function automatic logic [7:0] pick_lead(input int len);
        if (len == 2)
            return 8'($urandom_range(8'hC0, 8'hDF));
        else if (len == 3)
            return 8'($urandom_range(8'hE0, 8'hEF));
        else
            return 8'($urandom_range(8'hF0, 8'hF7));
    endfunction

    // one character, mostly well formed, sometimes broken
    function automatic void add_char();
        int kind;
        int len;
        int conts;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            text_q.push_back(8'($urandom_range(1, 127)));
        end
        else if (kind < 85) begin
            len = (kind < 50) ? 2 : (kind < 70) ? 3 : 4;
            text_q.push_back(pick_lead(len));
            repeat (len - 1) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 90) begin
            text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        else if (kind < 95) begin
            len = $urandom_range(2, 4);
            conts = $urandom_range(0, len - 2);
            text_q.push_back(pick_lead(len));
            repeat (conts) text_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
        end
        else begin
            text_q.push_back(8'($urandom_range(1, 255)));
        end
    endfunction

    // offer one byte and hold it until the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        in_byte    <= b;
        string_end <= last;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_string();
        int n;
        text_q.delete();
        n = $urandom_range(1, 8);
        repeat (n) add_char();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        strings_sent++;
    endtask

    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    // receiver: random stalls, plus one long hold on request
    initial
    begin
        int stall_len;
        bit hold_done;
        hold_done = 1'b0;
        out_stall <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                stall_len = HOLD_CYCLES;
            end
            else if (idle_on) begin
                stall_len = pick_gap();
            end
            else begin
                stall_len = 0;
            end
            if (stall_len > 0) begin
                out_stall <= 1'b1;
                repeat (stall_len) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        in_byte    <= 8'h00;
        string_end <= 1'b0;
        idle_on    = 1'b1;
        hold_req   = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        in_valid <= 1'b0;
        wait_drained();

        // back to back on both sides, then a long receiver hold
        idle_on = 1'b0;
        while (items_sent < 75) send_string();
        hold_req = 1'b1;
        while (items_sent < 120) send_string();

        idle_on = 1'b1;
        while (items_sent < 190) send_string();
        in_valid <= 1'b0;
        wait_drained();

        while (items_sent < 255) send_string();
        in_valid <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Sent %0d bytes in %0d strings, %0d code units compared.",
                 bytes_taken, strings_sent, units_checked);
        $display("Covered 1-4 byte forms, surrogate pairs, lenient flushes and stalls.");
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Run timed out with %0d code units pending.", pending);
        $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/utt_pkg.sv
rtl/core/utt_decode.sv
rtl/core/utt_outbuf.sv
rtl/core/utf8_to_utf16_transcoder_top.sv
rtl/core/utt_checker.sv
sim/utf16_unit_checker.sv
sim/tb.sv
